// File: src/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants
// field constants, share limits and queue entry type for the reconstruction block
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int MAX_SHARES_DEF = 16;
   localparam int PRIME_DEF      = 257;
   localparam int X_W            = 8;
   localparam int Y_W            = 9;
   localparam int F_W            = 9;

   typedef struct packed {
      logic [Y_W-1:0] y;
      logic [X_W-1:0] x;
      logic           last;
   } share_type;

   // reduce a value below 2*p by one compare and subtract
   function automatic logic [F_W-1:0] fold(input logic [F_W:0] v, input logic [F_W:0] p);
      logic [F_W:0] t;
      begin
         t = (v >= p) ? v - p : v;
         return t[F_W-1:0];
      end
   endfunction

endpackage

// File: src/ssr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_if: valid/ready channel
// carries one payload item with a valid/ready handshake
// ----------------------------------------------------------------------------
interface ssr_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/ssr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_front: share intake
// two-entry queue that takes shares and hands them to the engine
// ----------------------------------------------------------------------------
module ssr_front
   import ssr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  share_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output share_type out_data
);
   share_type q_ff [2];
   logic      rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q_ff[rd_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_data;
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: src/ssr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_back: share store and interpolation engine
// stores shares, then runs the lagrange sum with one shared mod multiplier
// ----------------------------------------------------------------------------
module ssr_back
   import ssr_pkg::*;
#(
   parameter int MAX_SHARES = MAX_SHARES_DEF
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  share_type      in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [F_W-1:0] out_secret,
   output logic           out_overflow
);
   localparam int IW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
   localparam int CW = $clog2(MAX_SHARES + 1);
   localparam logic [F_W:0] P = (F_W+1)'(PRIME_DEF);
   localparam logic [F_W-1:0] PM2 = F_W'(PRIME_DEF - 2);

   typedef enum logic [3:0] {
      S_LOAD, S_RDI, S_RDJ, S_NUM, S_DEN, S_INVSQ, S_INVMUL, S_T1, S_T2, S_OUT
   } state_type;

   logic [F_W-1:0] x_mem [MAX_SHARES];
   logic [F_W-1:0] y_mem [MAX_SHARES];

   state_type      st_ff;
   logic [CW-1:0]  cnt_ff, n_ff;
   logic           ovf_ff;
   logic [IW-1:0]  i_ff, j_ff;
   logic [F_W-1:0] xi_ff, yi_ff, xj_ff;
   logic [F_W-1:0] num_ff, den_ff, sum_ff, acc_ff, base_ff;
   logic [3:0]     eb_ff;
   logic [F_W-1:0] res_ff;
   logic           resovf_ff;

   // one shared mod-p multiplier
   logic [F_W-1:0] ma, mb, mr;
   logic [2*F_W-1:0] prod;
   logic [F_W:0]     red;
   assign prod = ma * mb;
   // 256 = -1 mod 257: fold the bits above bit 7 back by subtraction
   assign red  = {2'b0, prod[7:0]} + P - prod[2*F_W-1:8];
   assign mr   = fold(red, P);

   logic [F_W-1:0] negxj, dxi;
   assign negxj = (xj_ff == '0) ? '0 : F_W'(P - {1'b0, xj_ff});
   assign dxi   = fold({1'b0, xi_ff} + {1'b0, negxj}, P);

   logic [F_W:0] addsum;
   assign addsum = {1'b0, sum_ff} + {1'b0, mr};

   always_comb begin
      ma = num_ff; mb = negxj;
      case (st_ff)
         S_NUM:    begin ma = num_ff; mb = negxj; end
         S_DEN:    begin ma = den_ff; mb = dxi;   end
         S_INVSQ:  begin ma = acc_ff; mb = acc_ff; end
         S_INVMUL: begin ma = acc_ff; mb = base_ff; end
         S_T1:     begin ma = yi_ff;  mb = num_ff; end
         S_T2:     begin ma = num_ff; mb = acc_ff; end
         default:  begin ma = num_ff; mb = negxj; end
      endcase
   end

   assign in_ready     = (st_ff == S_LOAD);
   assign out_valid    = (st_ff == S_OUT);
   assign out_secret   = res_ff;
   assign out_overflow = resovf_ff;

   logic [F_W-1:0] xin, yin;
   assign xin = fold({2'b0, in_data.x}, P);
   assign yin = fold({1'b0, in_data.y}, P);

   always_ff @(posedge clock) begin
      if (st_ff == S_LOAD && in_valid && cnt_ff < CW'(MAX_SHARES)) begin
         x_mem[cnt_ff[IW-1:0]] <= xin;
         y_mem[cnt_ff[IW-1:0]] <= yin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         case (st_ff)
            S_LOAD: if (in_valid) begin
               if (cnt_ff < CW'(MAX_SHARES)) cnt_ff <= cnt_ff + 1'b1;
               else ovf_ff <= 1'b1;
               if (in_data.last) begin
                  n_ff <= (cnt_ff < CW'(MAX_SHARES)) ? cnt_ff + 1'b1 : cnt_ff;
                  resovf_ff <= ovf_ff | (cnt_ff >= CW'(MAX_SHARES));
                  i_ff <= '0; sum_ff <= '0;
                  st_ff <= S_RDI;
               end
            end
            S_RDI: begin
               xi_ff <= x_mem[i_ff]; yi_ff <= y_mem[i_ff];
               num_ff <= F_W'(1); den_ff <= F_W'(1); j_ff <= '0;
               st_ff <= S_RDJ;
            end
            S_RDJ: begin
               xj_ff <= x_mem[j_ff];
               if (j_ff == i_ff) begin
                  if (CW'(j_ff) + 1'b1 == n_ff) begin
                     acc_ff <= F_W'(1); base_ff <= den_ff; eb_ff <= 4'd8;
                     st_ff <= S_INVSQ;
                  end else j_ff <= j_ff + 1'b1;
               end else st_ff <= S_NUM;
            end
            S_NUM: begin num_ff <= mr; st_ff <= S_DEN; end
            S_DEN: begin
               den_ff <= mr;
               if (CW'(j_ff) + 1'b1 == n_ff) begin
                  acc_ff <= F_W'(1); base_ff <= mr; eb_ff <= 4'd8;
                  st_ff <= S_INVSQ;
               end else begin
                  j_ff <= j_ff + 1'b1; st_ff <= S_RDJ;
               end
            end
            // den^(p-2) by square and multiply, msb first; 0 maps to 0
            S_INVSQ: begin
               acc_ff <= mr;
               if (PM2[eb_ff]) st_ff <= S_INVMUL;
               else if (eb_ff == 4'd0) st_ff <= S_T1;
               else eb_ff <= eb_ff - 1'b1;
            end
            S_INVMUL: begin
               acc_ff <= mr;
               if (eb_ff == 4'd0) st_ff <= S_T1;
               else begin eb_ff <= eb_ff - 1'b1; st_ff <= S_INVSQ; end
            end
            S_T1: begin num_ff <= mr; st_ff <= S_T2; end
            S_T2: begin
               if (CW'(i_ff) + 1'b1 == n_ff) begin
                  res_ff <= fold(addsum, P);
                  st_ff <= S_OUT;
               end else begin
                  sum_ff <= fold(addsum, P);
                  i_ff <= i_ff + 1'b1; st_ff <= S_RDI;
               end
            end
            S_OUT: if (out_ready) begin
               cnt_ff <= '0; ovf_ff <= 1'b0; st_ff <= S_LOAD;
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end
endmodule

// File: src/shamir_secret_reconstruct_gf257.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shamir_secret_reconstruct_gf257: secret recovery over gf(p)
// collects shares and recovers the secret by lagrange interpolation at zero
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  req     | in  | share_x, share_y, last_share     | valid/ready
//  rsp     | out | secret_value, overflow           | valid/ready
//
//  a share that is not last is written to the share store
//  the last share starts interpolation: each (i,j) pair with i != j takes a read,
//  a numerator and a denominator step, and each share adds its own reads, a fermat
//  inversion by square and multiply and two term steps, all on one multiplier
//  synchronous active high reset; the share store needs no clearing
//  a two-entry intake queue takes up to two shares while the engine is busy
//  the result is held until rsp ready; the engine stalls meanwhile
// ----------------------------------------------------------------------------
module shamir_secret_reconstruct_gf257
   import ssr_pkg::*;
#(
   parameter int MAX_SHARES = MAX_SHARES_DEF
)(
   input  logic   clock,
   input  logic   reset,
   ssr_if.sink    req,
   ssr_if.source  rsp
);
   // queue between intake and engine
   logic      q_valid, q_ready;
   share_type in_item, q_item;
   logic [F_W-1:0] secret;
   logic           ovf;

   // request payload: {share_x, share_y, last_share}
   assign in_item.x    = req.data[Y_W+X_W:Y_W+1];
   assign in_item.y    = req.data[Y_W:1];
   assign in_item.last = req.data[0];

   ssr_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_data (in_item),
      .out_valid (q_valid), .out_ready (q_ready), .out_data (q_item)
   );

   ssr_back #(.MAX_SHARES(MAX_SHARES)) u_back (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_data (q_item),
      .out_valid (rsp.valid), .out_ready (rsp.ready),
      .out_secret (secret), .out_overflow (ovf)
   );

   // response payload: {secret_value, overflow}
   assign rsp.data = {secret, ovf};
endmodule
